// ----- sv/rgbblur_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbblur_pkg
// Shared widths, register codes and beat types of the cascaded RGB box blur.
// ----------------------------------------------------------------------------
package rgbblur_pkg;

  // channel and pixel widths
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SLOT_W = PIX_W + 1;

  // configuration register widths
  localparam int WID_W      = 11;
  localparam int HGT_W      = 16;
  localparam int PASS_CFG_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // per-stage and frame counters
  localparam int FILL_W = 11;
  localparam int EMIT_W = 26;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_PASSES_DEF = 6;

  // register values after reset
  localparam logic [WID_W-1:0]      RST_FRAME_WIDTH  = 11'd640;
  localparam logic [HGT_W-1:0]      RST_FRAME_HEIGHT = 16'd480;
  localparam logic [PASS_CFG_W-1:0] RST_PASS_COUNT   = 3'd1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PASS_COUNT   = 2'd2
  } cfg_reg_t;

  // one pixel slot: valid flag plus packed red, green, blue
  typedef struct packed {
    logic             v;
    logic [PIX_W-1:0] px;
  } slot_t;

  // one pipeline beat between stages; present marks a live beat
  typedef struct packed {
    logic  present;
    slot_t slot;
  } tok_t;

  // effective frame size seen by every stage
  typedef struct packed {
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
  } dims_t;

endpackage

// ----- sv/rgbblur_if.sv -----
// ----------------------------------------------------------------------------
// rgbblur channel interfaces
// Valid/ready channels for incoming pixels and for blurred result pixels.
// ----------------------------------------------------------------------------
interface rgbblur_in_if;
  import rgbblur_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic            is_padding;

  modport source (output valid, red_in, green_in, blue_in, is_padding, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, is_padding, output ready);
endinterface

interface rgbblur_out_if;
  import rgbblur_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ----- sv/rgbblur_ram.sv -----
// ----------------------------------------------------------------------------
// rgbblur_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rgbblur_ram #(
  parameter int WIDTH = 2 * rgbblur_pkg::SLOT_W,
  parameter int DEPTH = rgbblur_pkg::MAX_WIDTH_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rgbblur_stage.sv -----
// ----------------------------------------------------------------------------
// rgbblur_stage
// One blur pass: two-line store, 3x3 window and nine-pixel mean per channel.
// ----------------------------------------------------------------------------
module rgbblur_stage #(
  parameter int MAX_WIDTH = rgbblur_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                active,
  input  rgbblur_pkg::dims_t  dims,
  input  rgbblur_pkg::tok_t   tok_in,
  output rgbblur_pkg::tok_t   tok_out
);
  import rgbblur_pkg::*;

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W  = ((ADDR_W > WID_W) ? ADDR_W : WID_W) + 1;
  localparam int ROW_W  = HGT_W + 1;
  localparam int RAM_W  = 2 * SLOT_W;
  localparam int SUM_W  = CH_W + 4;
  // floor(x / 9) = (x * 7282) >> 16 for every sum of nine channel values
  localparam int DIV_SH = 16;
  localparam int MUL_W  = 13;
  localparam logic [MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int PROD_W = SUM_W + MUL_W;

  function automatic logic [CH_W-1:0] mean9(input logic [8:0][CH_W-1:0] v);
    logic [SUM_W-1:0]  s0;
    logic [SUM_W-1:0]  s1;
    logic [SUM_W-1:0]  s2;
    logic [SUM_W-1:0]  s;
    logic [PROD_W-1:0] p;
    s0 = SUM_W'(v[0]) + SUM_W'(v[1]) + SUM_W'(v[2]);
    s1 = SUM_W'(v[3]) + SUM_W'(v[4]) + SUM_W'(v[5]);
    s2 = SUM_W'(v[6]) + SUM_W'(v[7]) + SUM_W'(v[8]);
    s  = s0 + s1 + s2;
    p  = PROD_W'(s) * PROD_W'(DIV9_MUL);
    return p[DIV_SH +: CH_W];
  endfunction

  slot_t             win_r [3][3];
  slot_t             nwin  [3][3];
  logic [ADDR_W-1:0] col_r;
  logic [ADDR_W-1:0] ocol_r;
  logic [ADDR_W-1:0] laddr_r;
  logic [ADDR_W-1:0] laddr_nxt;
  logic [ADDR_W-1:0] ram_raddr;
  logic [HGT_W-1:0]  row_r;
  logic [HGT_W-1:0]  orow_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] fill_nxt;
  logic              primed_r;
  logic              byp_r;
  logic [RAM_W-1:0]  byp_data_r;
  logic [RAM_W-1:0]  ram_q;
  logic [RAM_W-1:0]  rd_word;
  logic [RAM_W-1:0]  wr_word;
  slot_t             top_s;
  slot_t             mid_s;
  slot_t             new_s;
  slot_t             ctr_s;
  logic              in_v;
  logic              ignore;
  logic              tick;
  logic              interior;
  logic              laddr_wrap;
  logic              col_wrap;
  logic              row_wrap;
  logic              ocol_wrap;
  logic              orow_wrap;
  logic [8:0][CH_W-1:0] red_win;
  logic [8:0][CH_W-1:0] grn_win;
  logic [8:0][CH_W-1:0] blu_win;
  logic [CH_W-1:0]   mean_red;
  logic [CH_W-1:0]   mean_grn;
  logic [CH_W-1:0]   mean_blu;

  // line store: upper line and middle line side by side at one address
  rgbblur_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (tick),
    .waddr (laddr_r),
    .wdata (wr_word),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // line store read: bypass for same-address write, blank until first wrap
  always_comb begin
    rd_word = byp_r ? byp_data_r : ram_q;
    top_s   = primed_r ? slot_t'(rd_word[RAM_W-1:SLOT_W]) : '0;
    mid_s   = primed_r ? slot_t'(rd_word[SLOT_W-1:0]) : '0;
  end

  // beat decode: padding inside a frame or into an empty stage is dropped
  always_comb begin
    in_v   = tok_in.slot.v;
    new_s  = in_v ? tok_in.slot : '0;
    ignore = !in_v && (col_r != '0 || row_r != '0 || fill_r == '0);
    tick   = rst_n && adv && active && tok_in.present && !ignore;
    ctr_s  = win_r[1][2];
  end

  // window shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nwin[r][0] = win_r[r][1];
      nwin[r][1] = win_r[r][2];
    end
    nwin[0][2] = top_s;
    nwin[1][2] = mid_s;
    nwin[2][2] = new_s;
    wr_word    = {mid_s, new_s};
  end

  // coordinate wraps and line address
  always_comb begin
    laddr_wrap = (CMP_W'(laddr_r) + CMP_W'(1)) >= CMP_W'(dims.w);
    col_wrap   = (CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(dims.w);
    ocol_wrap  = (CMP_W'(ocol_r) + CMP_W'(1)) >= CMP_W'(dims.w);
    row_wrap   = (ROW_W'(row_r) + ROW_W'(1)) >= ROW_W'(dims.h);
    orow_wrap  = (ROW_W'(orow_r) + ROW_W'(1)) >= ROW_W'(dims.h);
    if (tick) begin
      laddr_nxt = laddr_wrap ? '0 : laddr_r + ADDR_W'(1);
    end else begin
      laddr_nxt = laddr_r;
    end
    ram_raddr = rst_n ? laddr_nxt : '0;
  end

  // fill count: up on a pixel in, down on a pixel out
  always_comb begin
    fill_inc = (in_v && fill_r != '1) ? fill_r + FILL_W'(1) : fill_r;
    fill_nxt = (ctr_s.v && fill_inc != '0) ? fill_inc - FILL_W'(1) : fill_inc;
  end

  // interior test on the output position, and channel means
  always_comb begin
    interior = ocol_r != '0 && (CMP_W'(ocol_r) + CMP_W'(2)) <= CMP_W'(dims.w) &&
               orow_r != '0 && (ROW_W'(orow_r) + ROW_W'(2)) <= ROW_W'(dims.h);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        red_win[r*3+c] = nwin[r][c].px[2*CH_W +: CH_W];
        grn_win[r*3+c] = nwin[r][c].px[CH_W +: CH_W];
        blu_win[r*3+c] = nwin[r][c].px[0 +: CH_W];
      end
    end
    mean_red = mean9(red_win);
    mean_grn = mean9(grn_win);
    mean_blu = mean9(blu_win);
  end

  // outgoing beat; an inactive stage passes beats through untouched
  always_comb begin
    if (active) begin
      tok_out.present = tok_in.present;
      tok_out.slot.v  = tok_in.present && !ignore && ctr_s.v;
      tok_out.slot.px = interior ? {mean_red, mean_grn, mean_blu} : ctr_s.px;
    end else begin
      tok_out = tok_in;
    end
  end

  // stage state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
      col_r    <= '0;
      row_r    <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      laddr_r  <= '0;
      fill_r   <= '0;
      primed_r <= 1'b0;
    end else if (tick) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= nwin[r][c];
        end
      end
      laddr_r <= laddr_nxt;
      fill_r  <= fill_nxt;
      if (laddr_wrap) begin
        primed_r <= 1'b1;
      end
      if (in_v) begin
        col_r <= col_wrap ? '0 : col_r + ADDR_W'(1);
        if (col_wrap) begin
          row_r <= row_wrap ? '0 : row_r + HGT_W'(1);
        end
      end
      if (ctr_s.v) begin
        ocol_r <= ocol_wrap ? '0 : ocol_r + ADDR_W'(1);
        if (ocol_wrap) begin
          orow_r <= orow_wrap ? '0 : orow_r + HGT_W'(1);
        end
      end
    end
  end

  // write-to-read bypass for the line store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= tick && (ram_raddr == laddr_r);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_word;
  end

endmodule

// ----- sv/rgb_box_blur_3x3_multipass_core.sv -----
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_multipass_core
// Cascaded 3x3 box blur over a raster stream of RGB pixels, 1..MAX_PASSES passes.
// ----------------------------------------------------------------------------
// Usage
//   in_bus  : valid/ready beats of one pixel each (red, green, blue, is_padding).
//   out_bus : valid/ready beats of one blurred pixel, frame_last on the last one.
//   cfg_*   : write-only registers frame_width, frame_height, pass_count; write
//             only while no pixels are in flight.
// Throughput: one beat per cycle in steady state while out_bus takes beats; each
//   pass is one register stage with a one-port-read, one-port-write line RAM, so
//   nothing limits the rate below one beat per clock.
// Pipeline: input register, one register per pass, output register. Each active
//   pass also holds pixels back by frame_width + 1 beats, so after a frame the
//   source sends pass_count * (frame_width + 1) padding beats.
// Padding beats never produce a result of their own.
// Reset: synchronous, active low; registers return to 640 x 480 with one pass,
//   every pass forgets its window and line contents. No RAM clearing sweep.
// Stall: when out_bus is valid and not ready, the whole pipe holds and in_bus
//   ready drops in the same cycle; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_multipass_core #(
  parameter int MAX_WIDTH  = rgbblur_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PASSES = rgbblur_pkg::MAX_PASSES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  rgbblur_in_if.sink                            in_bus,
  rgbblur_out_if.source                         out_bus,
  input  logic                                  cfg_we,
  input  logic [rgbblur_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rgbblur_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rgbblur_pkg::*;

  localparam int PASS_W  = $clog2(MAX_PASSES + 1);
  localparam int TOTAL_W = WID_W + HGT_W;

  logic [WID_W-1:0]      frame_width_r;
  logic [HGT_W-1:0]      frame_height_r;
  logic [PASS_CFG_W-1:0] pass_count_r;
  logic [PASS_W-1:0]     eff_passes;
  dims_t                 dims;
  logic [TOTAL_W-1:0]    total_r;
  logic [EMIT_W-1:0]     emitted_r;
  logic                  last;
  logic                  adv;
  logic                  out_load;
  tok_t                  tok_r     [MAX_PASSES+1];
  tok_t                  stage_out [MAX_PASSES];
  logic                  out_valid_r;
  logic [PIX_W-1:0]      out_px_r;
  logic                  out_last_r;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      pass_count_r   <= RST_PASS_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[WID_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[HGT_W-1:0];
        REG_PASS_COUNT:   pass_count_r   <= cfg_wdata[PASS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective size and pass count, out-of-range values clamped
  always_comb begin
    if (frame_width_r == '0) begin
      dims.w = WID_W'(1);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      dims.w = WID_W'(MAX_WIDTH);
    end else begin
      dims.w = frame_width_r;
    end
    dims.h = (frame_height_r == '0) ? HGT_W'(1) : frame_height_r;
    if (pass_count_r == '0) begin
      eff_passes = PASS_W'(1);
    end else if (int'(pass_count_r) > MAX_PASSES) begin
      eff_passes = PASS_W'(MAX_PASSES);
    end else begin
      eff_passes = PASS_W'(pass_count_r);
    end
  end

  // pixels per frame
  always_ff @(posedge clk) begin
    total_r <= TOTAL_W'(dims.w) * TOTAL_W'(dims.h);
  end

  // global pipe enable: move whenever the output register can take a beat
  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r[0] <= '0;
    end else if (adv) begin
      tok_r[0].present  <= in_bus.valid;
      tok_r[0].slot.v   <= !in_bus.is_padding;
      tok_r[0].slot.px  <= {in_bus.red_in, in_bus.green_in, in_bus.blue_in};
    end
  end

  // blur passes in series, one register stage each
  for (genvar p = 0; p < MAX_PASSES; p++) begin : g_pass
    rgbblur_stage #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .active  (PASS_W'(p) < eff_passes),
      .dims    (dims),
      .tok_in  (tok_r[p]),
      .tok_out (stage_out[p])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tok_r[p+1] <= '0;
      end else if (adv) begin
        tok_r[p+1] <= stage_out[p];
      end
    end
  end

  // frame end marking
  always_comb begin
    out_load = tok_r[MAX_PASSES].present && tok_r[MAX_PASSES].slot.v;
    last     = (TOTAL_W'(emitted_r) + TOTAL_W'(1)) >= total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitted_r <= '0;
    end else if (adv && out_load) begin
      emitted_r <= last ? '0 : emitted_r + EMIT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && out_load) begin
      out_px_r   <= tok_r[MAX_PASSES].slot.px;
      out_last_r <= last;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.red_out    = out_px_r[2*CH_W +: CH_W];
  assign out_bus.green_out  = out_px_r[CH_W +: CH_W];
  assign out_bus.blue_out   = out_px_r[0 +: CH_W];
  assign out_bus.frame_last = out_last_r;

endmodule

// ----- sv/rgbblur_chk.sv -----
// ----------------------------------------------------------------------------
// rgbblur_chk
// Port-level checks of the blur core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rgbblur_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [3*rgbblur_pkg::CH_W:0]   out_payload
);
  import rgbblur_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("result payload changed while stalled");

  // while an input beat is offered, the input side is open exactly when the output register can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> (in_ready == (!out_valid || out_ready)))
    else $error("input ready does not follow output stall");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

endmodule

bind rgb_box_blur_3x3_multipass_core rgbblur_chk u_rgbblur_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_payload ({out_bus.red_out, out_bus.green_out, out_bus.blue_out, out_bus.frame_last})
);
